FILE: src/mfbe_pkg.sv
`default_nettype none

package mfbe_pkg;

  typedef enum logic [2:0] {
    ACT_SET        = 3'd0,
    ACT_GET        = 3'd1,
    ACT_FILL       = 3'd2,
    ACT_SHIFT_COL  = 3'd3,
    ACT_SHIFT_BIT  = 3'd4,
    ACT_SHIFT_PAGE = 3'd5,
    ACT_READ       = 3'd6
  } action_t;

  typedef enum logic [1:0] {
    SW_FILL = 2'd0,
    SW_COL  = 2'd1,
    SW_BIT  = 2'd2,
    SW_PAGE = 2'd3
  } sweep_kind_t;

  typedef struct packed {
    sweep_kind_t kind;
    logic        dir;
    logic        wrap;
    logic [7:0]  fill;
  } sweep_cmd_t;

  localparam logic REG_MIRROR = 1'b0;
  localparam logic REG_INVERT = 1'b1;

  localparam int WRAP_BIT = 3;

endpackage

`default_nettype wire

FILE: src/mfbe_ram.sv
`default_nettype none

module mfbe_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 864
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [DATA_W-1:0]        wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: src/mfbe_sweep.sv
`default_nettype none

module mfbe_sweep #(
  parameter int WIDTH = 96,
  parameter int PAGES = 9
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  input  wire mfbe_pkg::sweep_cmd_t             cmd,
  input  wire logic [7:0]                       rd_data,
  output logic                                  rd_en,
  output logic [$clog2(WIDTH*PAGES)-1:0]        rd_addr,
  output logic                                  wr_en,
  output logic [$clog2(WIDTH*PAGES)-1:0]        wr_addr,
  output logic [7:0]                            wr_data,
  output logic                                  done
);

  localparam int DEPTH  = WIDTH * PAGES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(WIDTH > PAGES ? WIDTH : PAGES);

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
  localparam logic [ADDR_W-1:0] COL_SPAN  = ADDR_W'(WIDTH - 1);
  localparam logic [ADDR_W-1:0] PAGE_SPAN = ADDR_W'((PAGES - 1) * WIDTH);
  localparam logic [ADDR_W-1:0] ONE_ADDR  = ADDR_W'(1);
  localparam logic [ADDR_W-1:0] ROW_ADDR  = ADDR_W'(WIDTH);
  localparam logic [CNT_W-1:0]  W_LAST    = CNT_W'(WIDTH - 1);
  localparam logic [CNT_W-1:0]  P_LAST    = CNT_W'(PAGES - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_RD_SEED,
    S_RD_ELEM,
    S_WR_ELEM
  } state_t;

  state_t               state_r;
  mfbe_pkg::sweep_cmd_t cmd_r;
  logic [ADDR_W-1:0]    cur_r;
  logic [ADDR_W-1:0]    lo_r;
  logic [CNT_W-1:0]     line_r;
  logic [CNT_W-1:0]     elem_r;
  logic                 first_r;
  logic [7:0]           prev_r;
  logic                 done_r;

  logic                 col_mode;
  logic                 asc;
  logic [ADDR_W-1:0]    hi;
  logic [ADDR_W-1:0]    elem_step;
  logic [ADDR_W-1:0]    line_step;
  logic [CNT_W-1:0]     elem_last;
  logic [CNT_W-1:0]     line_last;
  logic [7:0]           shift_data;

  assign col_mode  = (cmd_r.kind == mfbe_pkg::SW_COL);
  assign asc       = col_mode ? !cmd_r.dir : cmd_r.dir;
  assign hi        = lo_r + (col_mode ? COL_SPAN : PAGE_SPAN);
  assign elem_step = col_mode ? ONE_ADDR : ROW_ADDR;
  assign line_step = col_mode ? ROW_ADDR : ONE_ADDR;
  assign elem_last = col_mode ? W_LAST : P_LAST;
  assign line_last = col_mode ? P_LAST : W_LAST;

  // prev_r holds the seed on the first element of a line, else the previous old entry
  always_comb begin
    shift_data = 8'h00;
    if (cmd_r.kind == mfbe_pkg::SW_BIT) begin
      if (asc) begin
        shift_data = {rd_data[6:0],
                      first_r ? (cmd_r.wrap & prev_r[mfbe_pkg::WRAP_BIT]) : prev_r[7]};
      end else if (first_r) begin
        shift_data = {1'b0, rd_data[7:1]} |
                     ({7'b0, cmd_r.wrap & prev_r[0]} << mfbe_pkg::WRAP_BIT);
      end else begin
        shift_data = {prev_r[0], rd_data[7:1]};
      end
    end else if (first_r) begin
      shift_data = cmd_r.wrap ? prev_r : 8'h00;
    end else begin
      shift_data = prev_r;
    end
  end

  assign rd_en   = (state_r == S_RD_SEED) || (state_r == S_RD_ELEM);
  assign rd_addr = (state_r == S_RD_SEED) ? (asc ? hi : lo_r) : cur_r;
  assign wr_en   = (state_r == S_FILL) || (state_r == S_WR_ELEM);
  assign wr_addr = cur_r;
  assign wr_data = (state_r == S_FILL) ? cmd_r.fill : shift_data;
  assign done    = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_FILL;
      cmd_r   <= '0;
      cur_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            cmd_r   <= cmd;
            cur_r   <= '0;
            lo_r    <= '0;
            line_r  <= '0;
            state_r <= (cmd.kind == mfbe_pkg::SW_FILL) ? S_FILL : S_RD_SEED;
          end
        end
        S_FILL: begin
          if (cur_r == LAST_ADDR) begin
            done_r  <= 1'b1;
            state_r <= S_IDLE;
          end else begin
            cur_r <= cur_r + ONE_ADDR;
          end
        end
        S_RD_SEED: begin
          cur_r   <= asc ? lo_r : hi;
          elem_r  <= '0;
          first_r <= 1'b1;
          state_r <= S_RD_ELEM;
        end
        S_RD_ELEM: begin
          if (first_r) begin
            prev_r <= rd_data;
          end
          state_r <= S_WR_ELEM;
        end
        S_WR_ELEM: begin
          prev_r  <= rd_data;
          first_r <= 1'b0;
          if (elem_r == elem_last) begin
            if (line_r == line_last) begin
              done_r  <= 1'b1;
              state_r <= S_IDLE;
            end else begin
              line_r  <= line_r + CNT_W'(1);
              lo_r    <= lo_r + line_step;
              state_r <= S_RD_SEED;
            end
          end else begin
            elem_r  <= elem_r + CNT_W'(1);
            cur_r   <= asc ? (cur_r + elem_step) : (cur_r - elem_step);
            state_r <= S_RD_ELEM;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: src/mono_frame_buffer_engine_top.sv
// Channel  Handshake           Payload
// input    start / busy        in_action, in_pixel_x/y, in_pixel_value, in_fill_byte,
//                              in_shift_direction, in_wrap_enable, in_read_page/column
// result   out_valid (1 cyc)   out_pixel_out, out_display_byte, out_ignored
// config   cfg_we              cfg_index, cfg_data
//
// Set, get, read and unused actions: a store read on acceptance when in range, then
// S_PIXEL, which writes back an in-range set. Fill writes each store entry in turn.
// Shifts read a seed per line (a page for column shifts, a column for bit and page
// shifts), then read and write each entry. Reset clears the store with busy high.
// One result per item, shown for one cycle; the receiver cannot stall it.
`default_nettype none

module mono_frame_buffer_engine_top #(
  parameter int WIDTH  = 96,
  parameter int HEIGHT = 68,
  parameter int PAGES  = 9
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [2:0] in_action,
  input  wire logic [6:0] in_pixel_x,
  input  wire logic [6:0] in_pixel_y,
  input  wire logic       in_pixel_value,
  input  wire logic [7:0] in_fill_byte,
  input  wire logic       in_shift_direction,
  input  wire logic       in_wrap_enable,
  input  wire logic [3:0] in_read_page,
  input  wire logic [6:0] in_read_column,
  output logic            out_valid,
  output logic            out_pixel_out,
  output logic [7:0]      out_display_byte,
  output logic            out_ignored,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic       cfg_data
);

  localparam int DEPTH  = WIDTH * PAGES;
  localparam int ADDR_W = $clog2(DEPTH);

  typedef enum logic [1:0] {
    S_INIT,
    S_IDLE,
    S_PIXEL,
    S_SWEEP
  } state_t;

  state_t               state_r;
  mfbe_pkg::action_t    op_r;
  logic                 ok_r;
  logic [ADDR_W-1:0]    addr_r;
  logic [2:0]           bit_r;
  logic                 val_r;
  logic                 mirror_r;
  logic                 invert_r;
  logic                 out_valid_r;
  logic                 out_pixel_r;
  logic [7:0]           out_byte_r;
  logic                 out_ign_r;

  mfbe_pkg::action_t    act;
  logic                 accept;
  logic                 is_sweep;
  mfbe_pkg::sweep_cmd_t sw_cmd;
  logic [6:0]           flip;
  logic [3:0]           px_page;
  logic [6:0]           px_col;
  logic                 px_ok;
  logic [ADDR_W-1:0]    px_addr;
  logic                 rd_ok;
  logic [6:0]           rd_col;
  logic [ADDR_W-1:0]    rd_addr_d;
  logic [ADDR_W-1:0]    acc_addr;
  logic                 acc_ok;
  logic [7:0]           px_mask;
  logic [7:0]           px_new;

  logic                 sweep_active;
  logic                 sw_rd_en;
  logic [ADDR_W-1:0]    sw_rd_addr;
  logic                 sw_wr_en;
  logic [ADDR_W-1:0]    sw_wr_addr;
  logic [7:0]           sw_wr_data;
  logic                 sw_done;

  logic                 ram_rd_en;
  logic [ADDR_W-1:0]    ram_rd_addr;
  logic                 ram_wr_en;
  logic [ADDR_W-1:0]    ram_wr_addr;
  logic [7:0]           ram_wr_data;
  logic [7:0]           ram_rd_data;

  assign act    = mfbe_pkg::action_t'(in_action);
  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  assign is_sweep = (act == mfbe_pkg::ACT_FILL) || (act == mfbe_pkg::ACT_SHIFT_COL) ||
                    (act == mfbe_pkg::ACT_SHIFT_BIT) || (act == mfbe_pkg::ACT_SHIFT_PAGE);

  always_comb begin
    sw_cmd      = '0;
    sw_cmd.dir  = in_shift_direction;
    sw_cmd.wrap = in_wrap_enable;
    sw_cmd.fill = in_fill_byte;
    unique case (act)
      mfbe_pkg::ACT_SHIFT_COL:  sw_cmd.kind = mfbe_pkg::SW_COL;
      mfbe_pkg::ACT_SHIFT_BIT:  sw_cmd.kind = mfbe_pkg::SW_BIT;
      mfbe_pkg::ACT_SHIFT_PAGE: sw_cmd.kind = mfbe_pkg::SW_PAGE;
      default:                  sw_cmd.kind = mfbe_pkg::SW_FILL;
    endcase
  end

  // flipped pixel address
  assign flip    = 7'(HEIGHT - 1) - in_pixel_y;
  assign px_page = flip[6:3];
  assign px_col  = 7'(WIDTH - 1) - in_pixel_x;
  assign px_ok   = ({1'b0, in_pixel_x} < 8'(WIDTH)) && ({1'b0, in_pixel_y} < 8'(HEIGHT)) &&
                   ({1'b0, px_page} < 5'(PAGES));
  assign px_addr = ADDR_W'(px_page) * ADDR_W'(WIDTH) + ADDR_W'(px_col);

  assign rd_ok     = ({1'b0, in_read_page} < 5'(PAGES)) && ({1'b0, in_read_column} < 8'(WIDTH));
  assign rd_col    = mirror_r ? (7'(WIDTH - 1) - in_read_column) : in_read_column;
  assign rd_addr_d = ADDR_W'(in_read_page) * ADDR_W'(WIDTH) + ADDR_W'(rd_col);

  assign acc_addr = (act == mfbe_pkg::ACT_READ) ? rd_addr_d : px_addr;
  assign acc_ok   = (act == mfbe_pkg::ACT_READ) ? rd_ok :
                    ((act == mfbe_pkg::ACT_SET) || (act == mfbe_pkg::ACT_GET)) ? px_ok : 1'b0;

  assign px_mask = 8'b1 << bit_r;
  assign px_new  = val_r ? (ram_rd_data | px_mask) : (ram_rd_data & ~px_mask);

  assign sweep_active = (state_r == S_INIT) || (state_r == S_SWEEP);
  assign ram_rd_en    = sweep_active ? sw_rd_en : (accept && acc_ok);
  assign ram_rd_addr  = sweep_active ? sw_rd_addr : acc_addr;
  assign ram_wr_en    = sweep_active ? sw_wr_en :
                        ((state_r == S_PIXEL) && (op_r == mfbe_pkg::ACT_SET) && ok_r);
  assign ram_wr_addr  = sweep_active ? sw_wr_addr : addr_r;
  assign ram_wr_data  = sweep_active ? sw_wr_data : px_new;

  mfbe_ram #(
    .DATA_W (8),
    .DEPTH  (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  mfbe_sweep #(
    .WIDTH (WIDTH),
    .PAGES (PAGES)
  ) u_sweep (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (accept && is_sweep),
    .cmd     (sw_cmd),
    .rd_data (ram_rd_data),
    .rd_en   (sw_rd_en),
    .rd_addr (sw_rd_addr),
    .wr_en   (sw_wr_en),
    .wr_addr (sw_wr_addr),
    .wr_data (sw_wr_data),
    .done    (sw_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      mirror_r    <= 1'b0;
      invert_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          mfbe_pkg::REG_MIRROR: mirror_r <= cfg_data;
          mfbe_pkg::REG_INVERT: invert_r <= cfg_data;
        endcase
      end
      unique case (state_r)
        S_INIT: begin
          if (sw_done) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            op_r    <= act;
            ok_r    <= acc_ok;
            addr_r  <= acc_addr;
            bit_r   <= flip[2:0];
            val_r   <= in_pixel_value;
            state_r <= is_sweep ? S_SWEEP : S_PIXEL;
          end
        end
        S_PIXEL: begin
          out_valid_r <= 1'b1;
          out_pixel_r <= (op_r == mfbe_pkg::ACT_GET) && ok_r && ram_rd_data[bit_r];
          out_byte_r  <= ((op_r == mfbe_pkg::ACT_READ) && ok_r) ?
                         (ram_rd_data ^ {8{invert_r}}) : 8'h00;
          out_ign_r   <= (op_r == mfbe_pkg::ACT_SET) && !ok_r;
          state_r     <= S_IDLE;
        end
        S_SWEEP: begin
          if (sw_done) begin
            out_valid_r <= 1'b1;
            out_pixel_r <= 1'b0;
            out_byte_r  <= 8'h00;
            out_ign_r   <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_out    = out_pixel_r;
  assign out_display_byte = out_byte_r;
  assign out_ignored      = out_ign_r;

endmodule

`default_nettype wire

FILE: src/mfbe_checker.sv
`default_nettype none

module mfbe_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       out_valid,
  input wire logic       out_pixel_out,
  input wire logic [7:0] out_display_byte,
  input wire logic       out_ignored
);

  a_busy_after_reset: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy low right after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("item accepted but block not busy");

  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  a_no_double_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("two results in consecutive cycles");

  a_ignored_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ignored) |-> (!out_pixel_out && (out_display_byte == 8'h00)))
    else $error("ignored set carries data");

endmodule

bind mono_frame_buffer_engine_top mfbe_checker u_mfbe_checker (.*);

`default_nettype wire

FILE: verif/frame_store_checker.sv
`timescale 1ns / 100ps

module frame_store_checker #(
  parameter int WIDTH  = 96,
  parameter int HEIGHT = 68,
  parameter int PAGES  = 9
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire logic       busy,
  input  wire logic [2:0] in_action,
  input  wire logic [6:0] in_pixel_x,
  input  wire logic [6:0] in_pixel_y,
  input  wire logic       in_pixel_value,
  input  wire logic [7:0] in_fill_byte,
  input  wire logic       in_shift_direction,
  input  wire logic       in_wrap_enable,
  input  wire logic [3:0] in_read_page,
  input  wire logic [6:0] in_read_column,
  input  wire logic       out_valid,
  input  wire logic       out_pixel_out,
  input  wire logic [7:0] out_display_byte,
  input  wire logic       out_ignored,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic       cfg_data,
  output int              fail_count,
  output int              replies_due
);

  typedef struct {
    logic       pix;
    logic [7:0] dbyte;
    logic       ign;
  } reply_t;

  logic [7:0] fb [PAGES][WIDTH];
  logic       mirror_on;
  logic       invert_on;
  reply_t     due_replies [$];
  reply_t     want;
  int         mismatches = 0;

  task automatic apply_frame_op();
    reply_t     r;
    logic [7:0] keep [WIDTH];
    logic [7:0] k;
    logic [7:0] cur;
    logic       hit;
    logic       carry;
    int         flip;
    int         pg;
    int         bt;
    int         col;
    r.pix   = 1'b0;
    r.dbyte = 8'h00;
    r.ign   = 1'b0;
    hit  = (int'(in_pixel_x) < WIDTH) && (int'(in_pixel_y) < HEIGHT);
    flip = HEIGHT - 1 - int'(in_pixel_y);
    pg   = flip / 8;
    bt   = flip % 8;
    col  = WIDTH - 1 - int'(in_pixel_x);
    if (hit && pg >= PAGES) hit = 1'b0;
    case (in_action)
      mfbe_pkg::ACT_SET: begin
        if (hit) fb[pg][col][bt] = in_pixel_value;
        else r.ign = 1'b1;
      end
      mfbe_pkg::ACT_GET: begin
        if (hit) r.pix = fb[pg][col][bt];
      end
      mfbe_pkg::ACT_FILL: begin
        for (int p = 0; p < PAGES; p++)
          for (int c = 0; c < WIDTH; c++) fb[p][c] = in_fill_byte;
      end
      mfbe_pkg::ACT_SHIFT_COL: begin
        for (int p = 0; p < PAGES; p++) begin
          if (in_shift_direction) begin
            k = fb[p][0];
            for (int c = 0; c < WIDTH - 1; c++) fb[p][c] = fb[p][c + 1];
            fb[p][WIDTH - 1] = in_wrap_enable ? k : 8'h00;
          end else begin
            k = fb[p][WIDTH - 1];
            for (int c = WIDTH - 1; c > 0; c--) fb[p][c] = fb[p][c - 1];
            fb[p][0] = in_wrap_enable ? k : 8'h00;
          end
        end
      end
      mfbe_pkg::ACT_SHIFT_BIT: begin
        for (int c = 0; c < WIDTH; c++) begin
          if (in_shift_direction) begin
            carry = in_wrap_enable & fb[PAGES - 1][c][mfbe_pkg::WRAP_BIT];
            for (int p = PAGES - 1; p > 0; p--)
              fb[p][c] = {fb[p][c][6:0], fb[p - 1][c][7]};
            fb[0][c] = {fb[0][c][6:0], carry};
          end else begin
            carry = in_wrap_enable & fb[0][c][0];
            for (int p = 0; p < PAGES - 1; p++)
              fb[p][c] = {fb[p + 1][c][0], fb[p][c][7:1]};
            cur = fb[PAGES - 1][c] >> 1;
            cur[mfbe_pkg::WRAP_BIT] = cur[mfbe_pkg::WRAP_BIT] | carry;
            fb[PAGES - 1][c] = cur;
          end
        end
      end
      mfbe_pkg::ACT_SHIFT_PAGE: begin
        if (in_shift_direction) begin
          for (int c = 0; c < WIDTH; c++)
            keep[c] = in_wrap_enable ? fb[PAGES - 1][c] : 8'h00;
          for (int p = PAGES - 1; p > 0; p--)
            for (int c = 0; c < WIDTH; c++) fb[p][c] = fb[p - 1][c];
          for (int c = 0; c < WIDTH; c++) fb[0][c] = keep[c];
        end else begin
          for (int c = 0; c < WIDTH; c++)
            keep[c] = in_wrap_enable ? fb[0][c] : 8'h00;
          for (int p = 0; p < PAGES - 1; p++)
            for (int c = 0; c < WIDTH; c++) fb[p][c] = fb[p + 1][c];
          for (int c = 0; c < WIDTH; c++) fb[PAGES - 1][c] = keep[c];
        end
      end
      mfbe_pkg::ACT_READ: begin
        if (int'(in_read_page) < PAGES && int'(in_read_column) < WIDTH) begin
          col = mirror_on ? (WIDTH - 1 - int'(in_read_column)) : int'(in_read_column);
          r.dbyte = fb[in_read_page][col];
          if (invert_on) r.dbyte = ~r.dbyte;
        end
      end
      default: begin
      end
    endcase
    due_replies.push_back(r);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < PAGES; p++)
        for (int c = 0; c < WIDTH; c++) fb[p][c] = 8'h00;
      mirror_on = 1'b0;
      invert_on = 1'b0;
      due_replies.delete();
    end else begin
      if (out_valid) begin
        if (due_replies.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: pixel_out %0b display_byte %02h ignored %0b",
                     out_pixel_out, out_display_byte, out_ignored);
        end else begin
          want = due_replies.pop_front();
          if (want.pix !== out_pixel_out || want.dbyte !== out_display_byte ||
              want.ign !== out_ignored) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: pixel_out %0b/%0b display_byte %02h/%02h ignored %0b/%0b",
                       want.pix, out_pixel_out, want.dbyte, out_display_byte,
                       want.ign, out_ignored);
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == mfbe_pkg::REG_MIRROR) mirror_on = cfg_data;
        else invert_on = cfg_data;
      end
      if (start && !busy) apply_frame_op();
    end
    replies_due = due_replies.size();
    fail_count  = mismatches;
  end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int WIDTH  = 96;
  localparam int HEIGHT = 68;
  localparam int PAGES  = 9;
  localparam logic [2:0] ACT_UNUSED = 3'd7;
  localparam int PHASES = 5;
  localparam int PHASE_ITEMS = 185;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [2:0] in_action = '0;
  logic [6:0] in_pixel_x = '0;
  logic [6:0] in_pixel_y = '0;
  logic       in_pixel_value = 1'b0;
  logic [7:0] in_fill_byte = '0;
  logic       in_shift_direction = 1'b0;
  logic       in_wrap_enable = 1'b0;
  logic [3:0] in_read_page = '0;
  logic [6:0] in_read_column = '0;
  logic       out_valid;
  logic       out_pixel_out;
  logic [7:0] out_display_byte;
  logic       out_ignored;
  logic       cfg_we = 1'b0;
  logic       cfg_index = 1'b0;
  logic       cfg_data = 1'b0;
  int         fail_count;
  int         replies_due;

  logic       no_gaps = 1'b0;
  logic [6:0] recent_x [16];
  logic [6:0] recent_y [16];
  int         recent_n = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  mono_frame_buffer_engine_top #(
    .WIDTH (WIDTH),
    .HEIGHT(HEIGHT),
    .PAGES (PAGES)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_action         (in_action),
    .in_pixel_x        (in_pixel_x),
    .in_pixel_y        (in_pixel_y),
    .in_pixel_value    (in_pixel_value),
    .in_fill_byte      (in_fill_byte),
    .in_shift_direction(in_shift_direction),
    .in_wrap_enable    (in_wrap_enable),
    .in_read_page      (in_read_page),
    .in_read_column    (in_read_column),
    .out_valid         (out_valid),
    .out_pixel_out     (out_pixel_out),
    .out_display_byte  (out_display_byte),
    .out_ignored       (out_ignored),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  frame_store_checker #(
    .WIDTH (WIDTH),
    .HEIGHT(HEIGHT),
    .PAGES (PAGES)
  ) watch (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_action         (in_action),
    .in_pixel_x        (in_pixel_x),
    .in_pixel_y        (in_pixel_y),
    .in_pixel_value    (in_pixel_value),
    .in_fill_byte      (in_fill_byte),
    .in_shift_direction(in_shift_direction),
    .in_wrap_enable    (in_wrap_enable),
    .in_read_page      (in_read_page),
    .in_read_column    (in_read_column),
    .out_valid         (out_valid),
    .out_pixel_out     (out_pixel_out),
    .out_display_byte  (out_display_byte),
    .out_ignored       (out_ignored),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .fail_count        (fail_count),
    .replies_due       (replies_due)
  );

  // called and returns at a falling edge; start stays high after acceptance
  task automatic issue_op(input logic [2:0] act, input logic [6:0] x, input logic [6:0] y,
                          input logic v, input logic [7:0] fill, input logic dir,
                          input logic wrap, input logic [3:0] rp, input logic [6:0] rc);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_action          <= act;
    in_pixel_x         <= x;
    in_pixel_y         <= y;
    in_pixel_value     <= v;
    in_fill_byte       <= fill;
    in_shift_direction <= dir;
    in_wrap_enable     <= wrap;
    in_read_page       <= rp;
    in_read_column     <= rc;
    start              <= 1'b1;
    if (act == mfbe_pkg::ACT_SET) begin
      recent_x[recent_n % 16] = x;
      recent_y[recent_n % 16] = y;
      recent_n++;
    end
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (replies_due != 0 || busy) @(negedge clk);
  endtask

  task automatic set_regs(input logic mirror, input logic invert);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= mfbe_pkg::REG_MIRROR;
    cfg_data  <= mirror;
    @(negedge clk);
    cfg_index <= mfbe_pkg::REG_INVERT;
    cfg_data  <= invert;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic random_op();
    int         pick;
    int         slot;
    logic [2:0] act;
    logic [6:0] x;
    logic [6:0] y;
    logic [3:0] rp;
    logic [6:0] rc;
    pick = $urandom_range(0, 99);
    if (pick < 30) act = mfbe_pkg::ACT_SET;
    else if (pick < 55) act = mfbe_pkg::ACT_GET;
    else if (pick < 78) act = mfbe_pkg::ACT_READ;
    else if (pick < 82) act = mfbe_pkg::ACT_FILL;
    else if (pick < 86) act = mfbe_pkg::ACT_SHIFT_COL;
    else if (pick < 90) act = mfbe_pkg::ACT_SHIFT_BIT;
    else if (pick < 94) act = mfbe_pkg::ACT_SHIFT_PAGE;
    else if (pick < 97) act = ACT_UNUSED;
    else act = 3'($urandom_range(0, 7));
    if ($urandom_range(0, 99) < 85) begin
      x = 7'($urandom_range(0, WIDTH - 1));
      y = 7'($urandom_range(0, HEIGHT - 1));
    end else begin
      x = 7'($urandom_range(0, 127));
      y = 7'($urandom_range(0, 127));
    end
    if (act == mfbe_pkg::ACT_GET && recent_n > 0 && $urandom_range(0, 1)) begin
      slot = $urandom_range(0, 15);
      x = recent_x[slot];
      y = recent_y[slot];
    end
    rp = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) :
                                       4'($urandom_range(0, PAGES - 1));
    rc = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127)) :
                                       7'($urandom_range(0, WIDTH - 1));
    issue_op(act, x, y, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), rp, rc);
  endtask

  initial begin
    for (int i = 0; i < 16; i++) begin
      recent_x[i] = '0;
      recent_y[i] = '0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // corners, out of range pixels and reads, every shift flavor
    issue_op(mfbe_pkg::ACT_SET, 7'd0, 7'd0, 1'b1, 8'h00, 1'b0, 1'b0, 4'd0, 7'd0);
    issue_op(mfbe_pkg::ACT_SET, 7'd95, 7'd67, 1'b1, 8'h00, 1'b0, 1'b0, 4'd0, 7'd0);
    issue_op(mfbe_pkg::ACT_SET, 7'd0, 7'd67, 1'b1, 8'h00, 1'b0, 1'b0, 4'd0, 7'd0);
    issue_op(mfbe_pkg::ACT_SET, 7'd95, 7'd0, 1'b1, 8'h00, 1'b0, 1'b0, 4'd0, 7'd0);
    issue_op(mfbe_pkg::ACT_GET, 7'd0, 7'd0, 1'b0, 8'h00, 1'b0, 1'b0, 4'd0, 7'd0);
    issue_op(mfbe_pkg::ACT_GET, 7'd95, 7'd67, 1'b0, 8'h00, 1'b0, 1'b0, 4'd0, 7'd0);
    issue_op(mfbe_pkg::ACT_GET, 7'd96, 7'd0, 1'b0, 8'h00, 1'b0, 1'b0, 4'd0, 7'd0);
    issue_op(mfbe_pkg::ACT_SET, 7'd96, 7'd5, 1'b1, 8'h00, 1'b0, 1'b0, 4'd0, 7'd0);
    issue_op(mfbe_pkg::ACT_SET, 7'd5, 7'd68, 1'b1, 8'h00, 1'b0, 1'b0, 4'd0, 7'd0);
    issue_op(mfbe_pkg::ACT_SET, 7'd127, 7'd127, 1'b0, 8'h00, 1'b0, 1'b0, 4'd0, 7'd0);
    issue_op(mfbe_pkg::ACT_GET, 7'd127, 7'd127, 1'b0, 8'h00, 1'b0, 1'b0, 4'd0, 7'd0);
    issue_op(mfbe_pkg::ACT_READ, 7'd0, 7'd0, 1'b0, 8'h00, 1'b0, 1'b0, 4'd8, 7'd95);
    issue_op(mfbe_pkg::ACT_READ, 7'd0, 7'd0, 1'b0, 8'h00, 1'b0, 1'b0, 4'd0, 7'd0);
    issue_op(mfbe_pkg::ACT_READ, 7'd0, 7'd0, 1'b0, 8'h00, 1'b0, 1'b0, 4'd9, 7'd0);
    issue_op(mfbe_pkg::ACT_READ, 7'd0, 7'd0, 1'b0, 8'h00, 1'b0, 1'b0, 4'd15, 7'd127);
    issue_op(mfbe_pkg::ACT_SHIFT_BIT, 7'd0, 7'd0, 1'b0, 8'h00, 1'b1, 1'b1, 4'd0, 7'd0);
    issue_op(mfbe_pkg::ACT_SHIFT_BIT, 7'd0, 7'd0, 1'b0, 8'h00, 1'b0, 1'b1, 4'd0, 7'd0);
    issue_op(mfbe_pkg::ACT_SHIFT_COL, 7'd0, 7'd0, 1'b0, 8'h00, 1'b1, 1'b1, 4'd0, 7'd0);
    issue_op(mfbe_pkg::ACT_SHIFT_COL, 7'd0, 7'd0, 1'b0, 8'h00, 1'b0, 1'b0, 4'd0, 7'd0);
    issue_op(mfbe_pkg::ACT_SHIFT_PAGE, 7'd0, 7'd0, 1'b0, 8'h00, 1'b1, 1'b1, 4'd0, 7'd0);
    issue_op(mfbe_pkg::ACT_SHIFT_PAGE, 7'd0, 7'd0, 1'b0, 8'h00, 1'b0, 1'b0, 4'd0, 7'd0);
    issue_op(ACT_UNUSED, 7'd127, 7'd127, 1'b1, 8'hff, 1'b1, 1'b1, 4'd15, 7'd127);
    issue_op(mfbe_pkg::ACT_FILL, 7'd0, 7'd0, 1'b0, 8'hff, 1'b0, 1'b0, 4'd0, 7'd0);
    issue_op(mfbe_pkg::ACT_SHIFT_BIT, 7'd0, 7'd0, 1'b0, 8'h00, 1'b1, 1'b0, 4'd0, 7'd0);
    issue_op(mfbe_pkg::ACT_READ, 7'd0, 7'd0, 1'b0, 8'h00, 1'b0, 1'b0, 4'd0, 7'd0);

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: set_regs(1'b1, 1'b0);
        1: set_regs(1'b0, 1'b1);
        2: set_regs(1'b1, 1'b1);
        3: set_regs(1'b0, 1'b0);
        default: set_regs(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
        random_op();
      end
    end

    drain();
    repeat (20) @(negedge clk);
    if (fail_count == 0 && replies_due == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: mono_frame_buffer_engine_top.f
src/mfbe_pkg.sv
src/mfbe_ram.sv
src/mfbe_sweep.sv
src/mono_frame_buffer_engine_top.sv
src/mfbe_checker.sv
verif/frame_store_checker.sv
verif/testbench.sv
